>>> sv/stkm_pkg.sv
package stkm_pkg;

   localparam int DEPTH  = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int WORD_W = 32;

   localparam logic [1:0] ACT_PUSH = 2'd0;
   localparam logic [1:0] ACT_POP  = 2'd1;
   localparam logic [1:0] ACT_DEL  = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]               action;
      logic signed [WORD_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] removed_value;
      logic [1:0]               status;
      logic signed [WORD_W-1:0] middle_value;
      logic                     middle_valid;
      logic [CNT_W-1:0]         fill_count;
   } rsp_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [WORD_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

endpackage

>>> sv/stack_with_middle_ops_core.sv
// Bounded stack of 32-bit words with push, pop and delete of the middle word.
// The request channel carries one word per action; the response channel
// returns one word per request with the removed word, a status code, the
// word now at index count/2 and the fill count.
// Both channels use valid and stall; a word moves when valid is high and
// stall is low. The block takes one request at a time and raises req_stall
// from the cycle after acceptance until the response is loaded into the
// output register.
// Push and idle codes pass through the middle read and wait states to the
// done state; pop first waits for the popped word, and delete waits for the
// removed word and then shifts every word above the middle down one place.
// When the stack is empty after the step no middle word is read and the
// middle wait state is skipped. The shift runs through the single word
// memory, one read and one write for each moved word.
// A new request is accepted in the cycle after the response is loaded, even
// while that response is still held by a stalled receiver; the next response
// waits until the output register is free.
// Synchronous reset empties the stack and clears response valid; the memory
// contents are not cleared.
module stack_with_middle_ops_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  stkm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output stkm_pkg::rsp_type rsp_data
);
   import stkm_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_POP_WAIT,
      S_DEL_WAIT,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_MID_RD,
      S_MID_WAIT,
      S_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic [WORD_W-1:0] removed_ff, removed_in;
   logic [1:0]        status_ff, status_in;
   logic [WORD_W-1:0] middle_ff, middle_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   mem_req_type       mem_req;
   logic [WORD_W-1:0] rd_data;

   stkm_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      removed_in   = removed_ff;
      status_in    = status_ff;
      middle_in    = middle_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = ptr_ff;
      mem_req.wr_data = rd_data;
      mem_req.rd_en   = 1'b0;
      mem_req.rd_addr = ptr_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               removed_in = '0;
               status_in  = ST_OK;
               state_in   = S_MID_RD;
               unique case (req_data.action)
                  ACT_PUSH: begin
                     if (count_ff == CNT_W'(DEPTH)) begin
                        status_in = ST_FULL;
                     end else begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = ADDR_W'(count_ff);
                        mem_req.wr_data = req_data.push_value;
                        count_in        = count_ff + CNT_W'(1);
                     end
                  end
                  ACT_POP: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = ADDR_W'(count_ff - CNT_W'(1));
                        count_in        = count_ff - CNT_W'(1);
                        state_in        = S_POP_WAIT;
                     end
                  end
                  ACT_DEL: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = ADDR_W'(count_ff >> 1);
                        ptr_in          = ADDR_W'(count_ff >> 1);
                        state_in        = S_DEL_WAIT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_POP_WAIT: begin
            removed_in = rd_data;
            state_in   = S_MID_RD;
         end
         S_DEL_WAIT: begin
            removed_in = rd_data;
            state_in   = S_SHIFT_RD;
         end
         S_SHIFT_RD: begin
            if ((CNT_W'(ptr_ff) + CNT_W'(1)) < count_ff) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = ptr_ff + ADDR_W'(1);
               state_in        = S_SHIFT_WR;
            end else begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_MID_RD;
            end
         end
         S_SHIFT_WR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = ptr_ff;
            mem_req.wr_data = rd_data;
            ptr_in          = ptr_ff + ADDR_W'(1);
            state_in        = S_SHIFT_RD;
         end
         S_MID_RD: begin
            if (count_ff == '0) begin
               middle_in = '0;
               state_in  = S_DONE;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = ADDR_W'(count_ff >> 1);
               state_in        = S_MID_WAIT;
            end
         end
         S_MID_WAIT: begin
            middle_in = rd_data;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.removed_value  = removed_ff;
               rsp_data_in.status         = status_ff;
               rsp_data_in.middle_value   = middle_ff;
               rsp_data_in.middle_valid   = (count_ff != '0);
               rsp_data_in.fill_count     = count_ff;
               state_in                   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff      <= ptr_in;
      removed_ff  <= removed_in;
      status_ff   <= status_in;
      middle_ff   <= middle_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> sv/stkm_ram.sv
module stkm_ram (
   input  logic                           clock,
   input  stkm_pkg::mem_req_type          mem_req,
   output logic [stkm_pkg::WORD_W-1:0]    rd_data
);
   import stkm_pkg::*;

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/stkm_check.sv
module stkm_check (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input stkm_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input stkm_pkg::rsp_type rsp_data
);
   import stkm_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("response word changed while stalled");

   a_mid_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.middle_valid == (rsp_data.fill_count != '0)) &&
                    (rsp_data.middle_valid || rsp_data.middle_value == '0))
      else $error("middle word flag disagrees with fill count");

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.fill_count <= CNT_W'(DEPTH))
      else $error("fill count above capacity");

   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_FULL |->
         rsp_data.fill_count == CNT_W'(DEPTH) && rsp_data.removed_value == '0)
      else $error("full status with a stack that is not full");

endmodule

bind stack_with_middle_ops_core stkm_check u_check (.*);

>>> tb/sv/tb_stack_with_middle_ops_core.sv
`timescale 1ns / 100ps

module tb_stack_with_middle_ops_core;
   import stkm_pkg::*;

   localparam int QUIET_LIMIT   = 2000;
   localparam int TAIL_CYCLES   = 80;
   localparam int RANDOM_WORDS  = 850;
   localparam int LONG_HOLD     = 200;
   localparam int HOLD_AT       = 300;
   localparam int DRAIN_AT      = 520;
   localparam int REPORT_LIMIT  = 10;

   typedef struct {
      req_type word;
      bit      after_drain;
   } queued_word_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   queued_word_type pending[$];
   queued_word_type next_word;
   rsp_type         expected[$];

   logic signed [WORD_W-1:0] shadow_words [DEPTH];
   int shadow_count;

   bit req_taken;
   bit rsp_taken;
   int quiet_cycles;
   int mismatches;
   int results_seen;
   int n_push, n_pop, n_del, n_noop, n_full, n_empty, peak_fill;

   int send_gap;
   bit send_steady;
   int recv_wait;
   bit recv_steady;
   int hold_left;
   bit hold_done;

   stack_with_middle_ops_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic rsp_type apply_stack_op(req_type w);
      rsp_type r;
      int m;
      r = '0;
      r.status = ST_OK;
      case (w.action)
         ACT_PUSH: begin
            if (shadow_count >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               shadow_words[shadow_count] = w.push_value;
               shadow_count++;
            end
         end
         ACT_POP: begin
            if (shadow_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               shadow_count--;
               r.removed_value = shadow_words[shadow_count];
            end
         end
         ACT_DEL: begin
            if (shadow_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               m = shadow_count / 2;
               r.removed_value = shadow_words[m];
               for (int i = m; i + 1 < shadow_count; i++)
                  shadow_words[i] = shadow_words[i + 1];
               shadow_count--;
            end
         end
         default: ;
      endcase
      if (shadow_count != 0) begin
         r.middle_value = shadow_words[shadow_count / 2];
         r.middle_valid = 1'b1;
      end
      r.fill_count = shadow_count[CNT_W-1:0];
      return r;
   endfunction

   task automatic check_result(rsp_type got);
      rsp_type want;
      results_seen++;
      if (expected.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("unexpected result word: removed=%0d status=%0d middle=%0d/%0b count=%0d",
                     got.removed_value, got.status, got.middle_value, got.middle_valid,
                     got.fill_count);
      end else begin
         want = expected.pop_front();
         if (got.removed_value !== want.removed_value || got.status !== want.status ||
             got.middle_value !== want.middle_value ||
             got.middle_valid !== want.middle_valid || got.fill_count !== want.fill_count) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("result %0d: expected removed=%0d status=%0d middle=%0d/%0b count=%0d, %s",
                        results_seen, want.removed_value, want.status, want.middle_value,
                        want.middle_valid, want.fill_count,
                        $sformatf("got removed=%0d status=%0d middle=%0d/%0b count=%0d",
                                  got.removed_value, got.status, got.middle_value,
                                  got.middle_valid, got.fill_count));
         end
      end
   endtask

   function automatic logic [WORD_W-1:0] draw_value();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_word(logic [1:0] action, logic [WORD_W-1:0] value, bit after_drain);
      queued_word_type q;
      q.word.action     = action;
      q.word.push_value = value;
      q.after_drain     = after_drain;
      pending.push_back(q);
   endtask

   // Monitor and predictor: sample both handshakes at the rising edge.
   always @(posedge clock) begin
      req_taken = !reset && req_valid && !req_stall;
      rsp_taken = !reset && rsp_valid && !rsp_stall;
      if (rsp_taken)
         check_result(rsp_data);
      if (req_taken) begin
         expected.push_back(apply_stack_op(req_data));
         case (req_data.action)
            ACT_PUSH: n_push++;
            ACT_POP:  n_pop++;
            ACT_DEL:  n_del++;
            default:  n_noop++;
         endcase
         if (expected[$].status == ST_FULL) n_full++;
         if (expected[$].status == ST_EMPTY) n_empty++;
         if (shadow_count > peak_fill) peak_fill = shadow_count;
      end
      if (req_taken || rsp_taken || reset)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout with %0d results outstanding", expected.size());
         $display("simulation failed");
         $finish;
      end
   end

   // Request driver.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending.size() > 0 &&
                      !(pending[0].after_drain && expected.size() != 0)) begin
            next_word = pending.pop_front();
            req_valid <= 1'b1;
            req_data  <= next_word.word;
            if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
            send_gap = send_steady ? 0 : $urandom_range(0, 8);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response stall driver, with one long hold-off to back up the block.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_taken) begin
            if ($urandom_range(0, 39) == 0) recv_steady = !recv_steady;
            recv_wait = recv_steady ? 0 : $urandom_range(0, 8);
         end
         if (!hold_done && results_seen >= HOLD_AT) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (recv_wait > 0) begin
            recv_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int real_words;
      int seg_left;
      int seg_kind;
      int r;
      logic [1:0] act;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_stall = 1'b0;
      shadow_count = 0;

      // Empty-stack cases, single and double word deletes, value extremes.
      queue_word(ACT_POP, 32'h0, 1'b0);
      queue_word(ACT_DEL, 32'h0, 1'b0);
      queue_word(2'd3, 32'hFFFF_FFFF, 1'b0);
      queue_word(ACT_PUSH, 32'h7FFF_FFFF, 1'b0);
      queue_word(ACT_DEL, 32'h0, 1'b0);
      queue_word(ACT_PUSH, 32'h8000_0000, 1'b0);
      queue_word(ACT_PUSH, 32'hFFFF_FFFF, 1'b0);
      queue_word(ACT_DEL, 32'h0, 1'b0);
      queue_word(ACT_PUSH, 32'h0, 1'b0);
      queue_word(ACT_PUSH, 32'h5555_5555, 1'b0);
      queue_word(ACT_PUSH, 32'hAAAA_AAAA, 1'b0);
      queue_word(2'd3, 32'h1234_5678, 1'b0);
      queue_word(ACT_DEL, 32'h0, 1'b0);
      queue_word(ACT_PUSH, 32'h7FFF_FFFF, 1'b0);
      queue_word(ACT_DEL, 32'h0, 1'b0);
      queue_word(ACT_POP, 32'h0, 1'b0);
      queue_word(ACT_POP, 32'h0, 1'b0);
      queue_word(ACT_POP, 32'h0, 1'b0);
      queue_word(ACT_DEL, 32'h0, 1'b0);

      // Random part in segments that fill, drain or mix, so the stack
      // travels between empty and full many times.
      real_words = 0;
      seg_left   = 0;
      seg_kind   = 0;
      while (real_words < RANDOM_WORDS) begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(20, 120);
            seg_kind = $urandom_range(0, 2);
         end
         seg_left--;
         r = $urandom_range(0, 99);
         if (r < 3) begin
            act = 2'd3;
         end else begin
            r = $urandom_range(0, 99);
            case (seg_kind)
               0: act = (r < 80) ? ACT_PUSH : (r < 90) ? ACT_POP : ACT_DEL;
               1: act = (r < 15) ? ACT_PUSH : (r < 55) ? ACT_POP : ACT_DEL;
               default: act = (r < 40) ? ACT_PUSH : (r < 70) ? ACT_POP : ACT_DEL;
            endcase
            real_words++;
         end
         queue_word(act, draw_value(), real_words == DRAIN_AT && act != 2'd3);
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending.size() != 0 || req_valid) @(posedge clock);
      while (expected.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d results: %0d push, %0d pop, %0d delete, %0d idle codes",
               results_seen, n_push, n_pop, n_del, n_noop);
      $display("%0d dropped on full, %0d refused on empty, peak fill %0d of %0d",
               n_full, n_empty, peak_fill, DEPTH);
      if (mismatches == 0 && expected.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("simulation failed");
      end
      $finish;
   end

endmodule
